// File: sv/cmfs_pkg.sv
`timescale 1ns / 1ps

package cmfs_pkg;

  // Direction components are signed Q1.(IN_BITS-1)
  localparam int IN_BITS      = 16;
  // Coordinate scale: 2^UV_FRAC_BITS is 1.0
  localparam int UV_FRAC_BITS = 16;

  localparam int MAG_W  = IN_BITS;          // magnitude, holds 2^(IN_BITS-1)
  localparam int NUM_W  = IN_BITS + 1;      // s + m, range 0..2m
  localparam int UV_W   = UV_FRAC_BITS + 1; // quotient, range 0..2^UV_FRAC_BITS
  localparam int FACE_W = 3;

  // Front stages (input, compare, select) followed by one stage per quotient bit
  localparam int FRONT_STAGES = 3;
  localparam int NSTG         = FRONT_STAGES + UV_W;

  localparam logic [UV_W-1:0] UV_ONE = {1'b1, {UV_FRAC_BITS{1'b0}}};

  typedef enum logic [FACE_W-1:0] {
    FACE_NEG_X = 3'd0,
    FACE_POS_X = 3'd1,
    FACE_NEG_Y = 3'd2,
    FACE_POS_Y = 3'd3,
    FACE_NEG_Z = 3'd4,
    FACE_POS_Z = 3'd5
  } face_t;

  // One word in flight through the divider pipeline; u and v share the divisor
  typedef struct packed {
    face_t            face;
    logic             zero;
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] ru;
    logic [MAG_W-1:0] rv;
    logic [UV_W-1:0]  qu;
    logic [UV_W-1:0]  qv;
    logic [1:0]       nu;   // dividend bits still to shift in, MSB first
    logic [1:0]       nv;
  } div_t;

endpackage

// File: sv/cmfs_div_step.sv
`timescale 1ns / 1ps

// One restoring division step for both coordinates: shift in a dividend bit,
// compare against the divisor, subtract on success, append the quotient bit.
module cmfs_div_step (
  input  cmfs_pkg::div_t div_i,
  output cmfs_pkg::div_t div_o
);

  logic [cmfs_pkg::MAG_W:0] trial_u;
  logic [cmfs_pkg::MAG_W:0] trial_v;
  logic [cmfs_pkg::MAG_W:0] diff_u;
  logic [cmfs_pkg::MAG_W:0] diff_v;
  logic                     ge_u;
  logic                     ge_v;

  always_comb begin
    trial_u = {div_i.ru, div_i.nu[1]};
    trial_v = {div_i.rv, div_i.nv[1]};
    diff_u  = trial_u - {1'b0, div_i.m};
    diff_v  = trial_v - {1'b0, div_i.m};
    ge_u    = trial_u >= {1'b0, div_i.m};
    ge_v    = trial_v >= {1'b0, div_i.m};

    div_o    = div_i;
    div_o.ru = ge_u ? diff_u[cmfs_pkg::MAG_W-1:0] : trial_u[cmfs_pkg::MAG_W-1:0];
    div_o.rv = ge_v ? diff_v[cmfs_pkg::MAG_W-1:0] : trial_v[cmfs_pkg::MAG_W-1:0];
    div_o.qu = {div_i.qu[cmfs_pkg::UV_W-2:0], ge_u};
    div_o.qv = {div_i.qv[cmfs_pkg::UV_W-2:0], ge_v};
    div_o.nu = {div_i.nu[0], 1'b0};
    div_o.nv = {div_i.nv[0], 1'b0};
  end

endmodule

// File: sv/cube_map_face_select.sv
`timescale 1ns / 1ps

// Cube map face selection.
// Input channel: in_valid / in_stall carry one direction word (in_dir_x,
// in_dir_y, in_dir_z, signed Q1.15). Output channel: out_valid / out_stall
// carry the face (0 -x, 1 +x, 2 -y, 3 +y, 4 -z, 5 +z), the tile coordinates
// out_coord_u and out_coord_v (65536 = 1.0, v already flipped) and the
// out_zero_dir flag for an all-zero direction (face 5, coordinates 0).
// A word is taken at an edge where valid is high and stall is low.
// Throughput: one word per cycle while out_stall is low. From input accept to
// output valid a word passes the input register, major-axis compare, source
// select, then 17 restoring division steps, one quotient bit per stage, and
// the output register.
// Each stage moves whenever the stage after it is empty or moving, so bubbles
// close up and the input keeps flowing while a finished word waits at the
// output. With out_stall held, the pipeline fills and in_stall rises once all
// stages hold a word; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline; there is no
// configuration and no other state.
module cube_map_face_select (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [cmfs_pkg::IN_BITS-1:0] in_dir_x,
  input  logic signed [cmfs_pkg::IN_BITS-1:0] in_dir_y,
  input  logic signed [cmfs_pkg::IN_BITS-1:0] in_dir_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cmfs_pkg::FACE_W-1:0]     out_face,
  output logic [cmfs_pkg::UV_W-1:0]       out_coord_u,
  output logic [cmfs_pkg::UV_W-1:0]       out_coord_v,
  output logic                            out_zero_dir
);

  localparam int NSTG = cmfs_pkg::NSTG;
  localparam int UV_W = cmfs_pkg::UV_W;
  localparam int FS   = cmfs_pkg::FRONT_STAGES;

  // Pipeline control: one valid bit per stage, advance when the next one frees
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG:0]   adv;
  logic            out_valid_r;

  assign adv[NSTG] = !out_valid_r || !out_stall;
  genvar g;
  generate
    for (g = 0; g < NSTG; g++) begin : g_adv
      assign adv[g] = !vld_r[g] || adv[g+1];
    end
  endgenerate

  assign vld_nxt  = {vld_r[NSTG-2:0], in_valid};
  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (adv[i]) vld_r[i] <= vld_nxt[i];
      end
      if (adv[NSTG]) out_valid_r <= vld_r[NSTG-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: register the input word
  // ---------------------------------------------------------------------------
  logic [cmfs_pkg::IN_BITS-1:0] s0_x_r, s0_y_r, s0_z_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_x_r <= in_dir_x;
      s0_y_r <= in_dir_y;
      s0_z_r <= in_dir_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: magnitudes and major axis. Test faces in order -x, +x, -y, +y,
  // -z, +z; a zero component counts as negative. Zero vector forces +z.
  // ---------------------------------------------------------------------------
  localparam int MSB = cmfs_pkg::IN_BITS - 1;

  logic [cmfs_pkg::MAG_W-1:0] ax, ay, az;
  logic                       xmax, ymax, zmax;
  logic                       xpos, ypos, zpos;
  logic                       zero_nxt;
  cmfs_pkg::face_t            face_nxt;

  always_comb begin
    ax   = s0_x_r[MSB] ? (-s0_x_r) : s0_x_r;
    ay   = s0_y_r[MSB] ? (-s0_y_r) : s0_y_r;
    az   = s0_z_r[MSB] ? (-s0_z_r) : s0_z_r;
    xmax = (ax >= ay) && (ax >= az);
    ymax = (ay >= ax) && (ay >= az);
    zmax = (az >= ax) && (az >= ay);
    xpos = !s0_x_r[MSB] && (s0_x_r != '0);
    ypos = !s0_y_r[MSB] && (s0_y_r != '0);
    zpos = !s0_z_r[MSB] && (s0_z_r != '0);
    zero_nxt = (s0_x_r == '0) && (s0_y_r == '0) && (s0_z_r == '0);

    if (zero_nxt)            face_nxt = cmfs_pkg::FACE_POS_Z;
    else if (!xpos && xmax)  face_nxt = cmfs_pkg::FACE_NEG_X;
    else if (xpos && xmax)   face_nxt = cmfs_pkg::FACE_POS_X;
    else if (!ypos && ymax)  face_nxt = cmfs_pkg::FACE_NEG_Y;
    else if (ypos && ymax)   face_nxt = cmfs_pkg::FACE_POS_Y;
    else if (!zpos && zmax)  face_nxt = cmfs_pkg::FACE_NEG_Z;
    else                     face_nxt = cmfs_pkg::FACE_POS_Z;
  end

  logic [cmfs_pkg::IN_BITS-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [cmfs_pkg::MAG_W-1:0]   s1_ax_r, s1_ay_r, s1_az_r;
  cmfs_pkg::face_t              s1_face_r;
  logic                         s1_zero_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_x_r    <= s0_x_r;
      s1_y_r    <= s0_y_r;
      s1_z_r    <= s0_z_r;
      s1_ax_r   <= ax;
      s1_ay_r   <= ay;
      s1_az_r   <= az;
      s1_face_r <= face_nxt;
      s1_zero_r <= zero_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: pick divisor and sources, form dividends s + m (0..2m).
  // The quotient has UV_W bits, so the starting remainder is num >> 2 and the
  // two low dividend bits shift in first, then zeros.
  // ---------------------------------------------------------------------------
  localparam int NUM_W = cmfs_pkg::NUM_W;

  logic [NUM_W-1:0]           ex, ey, ez;
  logic [NUM_W-1:0]           su, sv, num_u, num_v;
  logic [cmfs_pkg::MAG_W-1:0] m_sel;
  cmfs_pkg::div_t             div_init;

  always_comb begin
    ex = {s1_x_r[MSB], s1_x_r};
    ey = {s1_y_r[MSB], s1_y_r};
    ez = {s1_z_r[MSB], s1_z_r};

    unique case (s1_face_r)
      cmfs_pkg::FACE_NEG_X: begin m_sel = s1_ax_r; su = ez;            sv = ey;            end
      cmfs_pkg::FACE_POS_X: begin m_sel = s1_ax_r; su = -ez;           sv = ey;            end
      cmfs_pkg::FACE_NEG_Y: begin m_sel = s1_ay_r; su = ex;            sv = ez;            end
      cmfs_pkg::FACE_POS_Y: begin m_sel = s1_ay_r; su = ex;            sv = -ez;           end
      cmfs_pkg::FACE_NEG_Z: begin m_sel = s1_az_r; su = -ex;           sv = ey;            end
      default:              begin m_sel = s1_az_r; su = ex;            sv = ey;            end
    endcase

    num_u = su + {1'b0, m_sel};
    num_v = sv + {1'b0, m_sel};

    // Zero vector: divide 0 by 1 so both quotients come out zero
    if (s1_zero_r) begin
      m_sel = {{(cmfs_pkg::MAG_W-1){1'b0}}, 1'b1};
      num_u = '0;
      num_v = '0;
    end

    div_init.face = s1_face_r;
    div_init.zero = s1_zero_r;
    div_init.m    = m_sel;
    div_init.ru   = {1'b0, num_u[NUM_W-1:2]};
    div_init.rv   = {1'b0, num_v[NUM_W-1:2]};
    div_init.qu   = '0;
    div_init.qv   = '0;
    div_init.nu   = num_u[1:0];
    div_init.nv   = num_v[1:0];
  end

  cmfs_pkg::div_t s2_div_r;

  always_ff @(posedge clk) begin
    if (adv[2]) s2_div_r <= div_init;
  end

  // ---------------------------------------------------------------------------
  // Division pipeline: one quotient bit per stage for u and v
  // ---------------------------------------------------------------------------
  cmfs_pkg::div_t div_r   [UV_W];
  cmfs_pkg::div_t div_nxt [UV_W];

  generate
    for (g = 0; g < UV_W; g++) begin : g_div
      if (g == 0) begin : g_first
        cmfs_div_step u_step (.div_i(s2_div_r), .div_o(div_nxt[g]));
      end else begin : g_rest
        cmfs_div_step u_step (.div_i(div_r[g-1]), .div_o(div_nxt[g]));
      end

      always_ff @(posedge clk) begin
        if (adv[FS+g]) div_r[g] <= div_nxt[g];
      end
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Output register: flip v, hold while stalled
  // ---------------------------------------------------------------------------
  logic [cmfs_pkg::FACE_W-1:0] out_face_r;
  logic [UV_W-1:0]             out_u_r, out_v_r, v_nxt;
  logic                        out_zero_r;

  assign v_nxt = div_r[UV_W-1].zero ? '0 : (cmfs_pkg::UV_ONE - div_r[UV_W-1].qv);

  always_ff @(posedge clk) begin
    if (adv[NSTG]) begin
      out_face_r <= div_r[UV_W-1].face;
      out_u_r    <= div_r[UV_W-1].qu;
      out_v_r    <= v_nxt;
      out_zero_r <= div_r[UV_W-1].zero;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_face     = out_face_r;
  assign out_coord_u  = out_u_r;
  assign out_coord_v  = out_v_r;
  assign out_zero_dir = out_zero_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zero_r |->
      out_face_r == cmfs_pkg::FACE_POS_Z && out_u_r == '0 && out_v_r == '0)
    else $error("zero direction word has wrong face or coordinates");

  a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_u_r <= cmfs_pkg::UV_ONE && out_v_r <= cmfs_pkg::UV_ONE)
    else $error("coordinate above full scale");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] |->
      div_r[UV_W-1].ru < div_r[UV_W-1].m && div_r[UV_W-1].rv < div_r[UV_W-1].m)
    else $error("division remainder not below divisor");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r) && out_valid_r && out_stall)
    else $error("input stalled while the pipeline has room");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && vld_r[NSTG-1] |=> vld_r[NSTG-1] && out_valid_r)
    else $error("word lost in last stage during output stall");

endmodule
